// ===== hdl/temperature_alarm_hysteresis_defines.svh =====
// ----------------------------------------------------------------------------
// temperature_alarm_hysteresis_defines.svh
// Assertion macros shared by the temperature alarm checker.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_ALARM_HYSTERESIS_DEFINES_SVH
`define TEMPERATURE_ALARM_HYSTERESIS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TAH_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("temperature alarm check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TAH_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("temperature alarm check failed");

`endif

// ===== hdl/tah_pkg.sv =====
// ----------------------------------------------------------------------------
// tah_pkg
// Widths, register indexes and shared types of the temperature alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tah_pkg;

  localparam int TEMP_W     = 15;  // signed tenths of a degree
  localparam int LIMIT_W    = 10;  // margin and hysteresis, unsigned tenths
  localparam int THR_W      = TEMP_W + 2;  // threshold sums never wrap
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TEMP_W;

  localparam logic [LIMIT_W-1:0] HYST_RESET = LIMIT_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET  = 2'd0,
    REG_MINIMUM = 2'd1,
    REG_MARGIN  = 2'd2,
    REG_HYST    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic signed [TEMP_W-1:0] minimum_temp;
    logic        [LIMIT_W-1:0] prewarn_margin;
    logic        [LIMIT_W-1:0] hysteresis;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic prewarn;
    logic outside;
  } flags_t;

endpackage

// ===== hdl/tah_if.sv =====
// ----------------------------------------------------------------------------
// tah_if
// Valid/ready channels of the temperature alarm: samples, results, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tah_in_if;
  logic                              valid;
  logic                              ready;
  logic                              probe_present;
  logic signed [tah_pkg::TEMP_W-1:0] sample_temp;

  modport source (output valid, probe_present, sample_temp, input ready);
  modport sink   (input valid, probe_present, sample_temp, output ready);
endinterface

interface tah_out_if;
  logic valid;
  logic ready;
  logic alarm;
  logic prewarn;

  modport source (output valid, alarm, prewarn, input ready);
  modport sink   (input valid, alarm, prewarn, output ready);
endinterface

interface tah_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tah_pkg::CFG_IDX_W-1:0]     index;
  logic [tah_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tah_eval.sv =====
// ----------------------------------------------------------------------------
// tah_eval
// Threshold compares and flag update for one temperature sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tah_eval (
  input  tah_pkg::cfg_t                     cfg,
  input  tah_pkg::flags_t                   flags,
  input  logic                              probe_present,
  input  logic signed [tah_pkg::TEMP_W-1:0] sample_temp,
  output logic                              alarm,
  output logic                              prewarn,
  output tah_pkg::flags_t                   flags_nxt
);
  import tah_pkg::*;

  logic signed [THR_W-1:0] t;
  logic signed [THR_W-1:0] tgt;
  logic signed [THR_W-1:0] mn;
  logic signed [THR_W-1:0] hy;
  logic signed [THR_W-1:0] mg;
  logic signed [THR_W-1:0] tgt_rearm;
  logic signed [THR_W-1:0] pre;
  logic signed [THR_W-1:0] pre_rearm;
  logic signed [THR_W-1:0] min_rearm;
  logic                    enabled;
  logic                    at_target;
  logic                    at_pre;
  logic                    out_of_range;
  logic                    back_inside;

  assign t   = THR_W'(sample_temp);
  assign tgt = THR_W'(cfg.target_temp);
  assign mn  = THR_W'(cfg.minimum_temp);
  assign hy  = signed'({{(THR_W-LIMIT_W){1'b0}}, cfg.hysteresis});
  assign mg  = signed'({{(THR_W-LIMIT_W){1'b0}}, cfg.prewarn_margin});

  assign tgt_rearm = tgt - hy;
  assign pre       = tgt - mg;
  assign pre_rearm = pre - hy;
  assign min_rearm = mn + hy;

  assign enabled      = probe_present && (cfg.target_temp != '0);
  assign at_target    = t >= tgt;
  assign at_pre       = t >= pre;
  assign out_of_range = (t < mn) || (t > tgt);
  assign back_inside  = (t > min_rearm) && (t < tgt_rearm);

  always_comb begin
    flags_nxt = flags;
    alarm     = 1'b0;
    prewarn   = 1'b0;
    if (enabled) begin
      if (cfg.minimum_temp == '0) begin
        alarm         = at_target && !flags.ready;
        flags_nxt.ready = at_target || (flags.ready && !(t < tgt_rearm));
        if (cfg.prewarn_margin != '0) begin
          prewarn           = at_pre && !flags.prewarn;
          flags_nxt.prewarn = at_pre || (flags.prewarn && !(t < pre_rearm));
        end
      end else begin
        // an inverted range is always outside, so it never re-arms
        alarm             = out_of_range && !flags.outside;
        flags_nxt.outside = out_of_range || (flags.outside && !back_inside);
      end
    end
  end

endmodule

// ===== hdl/temperature_alarm_hysteresis.sv =====
// ----------------------------------------------------------------------------
// temperature_alarm_hysteresis
// Pipeline: input register, then result register; an output stall holds both.
// One item per cycle when out_if is ready; flag update settles in one compare stage.
// Reset (rst_n low, synchronous): pipeline empty, all alarm flags clear,
// target 0, minimum 0, margin 0, hysteresis 20. Config writes are always accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module temperature_alarm_hysteresis (
  input  logic      clk,
  input  logic      rst_n,
  tah_in_if.sink    in_if,
  tah_out_if.source out_if,
  tah_cfg_if.sink   cfg_if
);
  import tah_pkg::*;

  cfg_t                     cfg_r,   cfg_nxt;
  flags_t                   flags_r, flags_nxt;
  flags_t                   flags_eval;
  logic                     s1_valid_r;
  logic                     s1_probe_r;
  logic signed [TEMP_W-1:0] s1_temp_r;
  logic                     out_valid_r;
  logic                     out_alarm_r;
  logic                     out_prewarn_r;
  logic                     alarm_c;
  logic                     prewarn_c;
  logic                     s2_ready;
  logic                     s1_ready;
  logic                     s1_move;
  logic                     cfg_wr;

  assign s2_ready = !out_valid_r || out_if.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_move  = s1_valid_r && s2_ready;

  assign in_if.ready   = s1_ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.alarm  = out_alarm_r;
  assign out_if.prewarn = out_prewarn_r;
  assign cfg_if.ready  = 1'b1;
  assign cfg_wr        = cfg_if.valid;

  tah_eval u_eval (
    .cfg           (cfg_r),
    .flags         (flags_r),
    .probe_present (s1_probe_r),
    .sample_temp   (s1_temp_r),
    .alarm         (alarm_c),
    .prewarn       (prewarn_c),
    .flags_nxt     (flags_eval)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_if.index))
        REG_TARGET:  cfg_nxt.target_temp    = signed'(cfg_if.data);
        REG_MINIMUM: cfg_nxt.minimum_temp   = signed'(cfg_if.data);
        REG_MARGIN:  cfg_nxt.prewarn_margin = cfg_if.data[LIMIT_W-1:0];
        REG_HYST:    cfg_nxt.hysteresis     = cfg_if.data[LIMIT_W-1:0];
      endcase
    end
  end

  // writing a limit clears the flags of the mode it leaves selected
  always_comb begin
    flags_nxt = flags_r;
    priority if (cfg_wr && (cfg_idx_t'(cfg_if.index) == REG_TARGET ||
                            cfg_idx_t'(cfg_if.index) == REG_MINIMUM)) begin
      if (cfg_nxt.minimum_temp == '0) begin
        flags_nxt.ready   = 1'b0;
        flags_nxt.prewarn = 1'b0;
      end else begin
        flags_nxt.outside = 1'b0;
      end
    end else if (s1_move) begin
      flags_nxt = flags_eval;
    end else begin
      flags_nxt = flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{target_temp: '0, minimum_temp: '0,
                       prewarn_margin: '0, hysteresis: HYST_RESET};
      flags_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      flags_r <= flags_nxt;
      if (s1_ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_if.valid) begin
      s1_probe_r <= in_if.probe_present;
      s1_temp_r  <= in_if.sample_temp;
    end
    if (s1_move) begin
      out_alarm_r   <= alarm_c;
      out_prewarn_r <= prewarn_c;
    end
  end

endmodule

// ===== hdl/tah_checker.sv =====
// ----------------------------------------------------------------------------
// tah_checker
// Port-level checks of the temperature alarm, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "temperature_alarm_hysteresis_defines.svh"

module tah_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_alarm,
  input logic out_prewarn,
  input logic cfg_valid,
  input logic cfg_ready
);

  logic [1:0] inflight_r;
  logic       last_alarm_r;
  logic       last_prewarn_r;
  logic       in_acc;
  logic       out_acc;
  logic       cfg_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_acc = cfg_valid && cfg_ready;

  // last_*: flag of the previous delivered item, forgotten on any config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r     <= '0;
      last_alarm_r   <= 1'b0;
      last_prewarn_r <= 1'b0;
    end else begin
      inflight_r <= inflight_r + 2'(in_acc) - 2'(out_acc);
      if (cfg_acc) begin
        last_alarm_r   <= 1'b0;
        last_prewarn_r <= 1'b0;
      end else if (out_acc) begin
        last_alarm_r   <= out_alarm;
        last_prewarn_r <= out_prewarn;
      end
    end
  end

  `TAH_CHECK_NEXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_alarm) && $stable(out_prewarn))
  `TAH_CHECK(a_inflight_max, 1'b1, inflight_r != 2'd3)
  `TAH_CHECK(a_no_phantom, out_valid, inflight_r != 2'd0)
  `TAH_CHECK(a_alarm_once, out_acc && out_alarm, !last_alarm_r)
  `TAH_CHECK(a_prewarn_once, out_acc && out_prewarn, !last_prewarn_r)

endmodule

bind temperature_alarm_hysteresis tah_checker u_tah_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_alarm   (out_if.alarm),
  .out_prewarn (out_if.prewarn),
  .cfg_valid   (cfg_if.valid),
  .cfg_ready   (cfg_if.ready)
);

// ===== verif/temperature_alarm_hysteresis_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_alarm_hysteresis_tb
// Self-checking bench for the temperature alarm. Samples go in over a
// valid/ready channel with bursty timing, results come back under a stalling
// receiver, and an in-bench copy of the alarm flags predicts every result.
// Directed checks of reset, target mode and range mode come first, then a
// long output hold-off and a series of random register settings.
// ----------------------------------------------------------------------------
module temperature_alarm_hysteresis_tb;
  import tah_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_REPORTS = 10;
  localparam int TEMP_MAX    = 2**(TEMP_W-1) - 1;
  localparam int TEMP_MIN    = -(2**(TEMP_W-1));

  typedef struct packed {
    logic alarm;
    logic prewarn;
  } alarm_res_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  tah_in_if  sample_ch ();
  tah_out_if result_ch ();
  tah_cfg_if cfg_ch ();

  temperature_alarm_hysteresis u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (sample_ch),
    .out_if (result_ch),
    .cfg_if (cfg_ch)
  );

  // shadow of the block: registers, flags and pending results
  cfg_t       cfg_q;
  flags_t     flags_q;
  alarm_res_t alarm_q[$];

  int sent_items    = 0;
  int checked_items = 0;
  int cfg_writes    = 0;
  int alarms_seen   = 0;
  int prewarns_seen = 0;
  int in_stalls     = 0;
  int mismatches    = 0;
  int cycle_cnt     = 0;

  int         burst_left = 0;
  bit         gaps_on    = 1'b0;
  rx_mode_e   rx_mode    = RX_ALWAYS;
  logic [7:0] rx_pat     = 8'hff;
  bit         hold_request = 1'b0;
  int         hold_left  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alarm_res_t predict_alarm(logic present,
                                               logic signed [TEMP_W-1:0] temp);
    alarm_res_t res;
    int t, tgt, lo, hyst, pre;
    res  = '0;
    t    = int'(temp);
    tgt  = int'($signed(cfg_q.target_temp));
    lo   = int'($signed(cfg_q.minimum_temp));
    hyst = int'(cfg_q.hysteresis);
    pre  = tgt - int'(cfg_q.prewarn_margin);
    if (present && tgt != 0) begin
      if (lo == 0) begin
        if (t >= tgt && !flags_q.ready) begin
          flags_q.ready = 1'b1;
          res.alarm = 1'b1;
        end
        if (t < tgt - hyst && flags_q.ready) flags_q.ready = 1'b0;
        if (cfg_q.prewarn_margin != '0) begin
          if (t >= pre && !flags_q.prewarn) begin
            flags_q.prewarn = 1'b1;
            res.prewarn = 1'b1;
          end
          if (t < pre - hyst && flags_q.prewarn) flags_q.prewarn = 1'b0;
        end
      end else begin
        if ((t < lo || t > tgt) && !flags_q.outside) begin
          flags_q.outside = 1'b1;
          res.alarm = 1'b1;
        end
        // an inverted range can never satisfy this, so the flag stays set
        if (t > lo + hyst && t < tgt - hyst && flags_q.outside) flags_q.outside = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic void apply_reg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_TARGET:  cfg_q.target_temp    = value;
      REG_MINIMUM: cfg_q.minimum_temp   = value;
      REG_MARGIN:  cfg_q.prewarn_margin = value[LIMIT_W-1:0];
      REG_HYST:    cfg_q.hysteresis     = value[LIMIT_W-1:0];
      default: ;
    endcase
    // limit writes clear the flags of the mode selected after the write
    if (idx == REG_TARGET || idx == REG_MINIMUM) begin
      if (cfg_q.minimum_temp == '0) begin
        flags_q.ready   = 1'b0;
        flags_q.prewarn = 1'b0;
      end else begin
        flags_q.outside = 1'b0;
      end
    end
  endfunction

  function automatic logic signed [TEMP_W-1:0] to_temp(int v);
    if (v > TEMP_MAX) v = TEMP_MAX;
    if (v < TEMP_MIN) v = TEMP_MIN;
    return TEMP_W'(v);
  endfunction

  // prediction on accept, check of each result against the oldest prediction
  always @(posedge clk) begin
    alarm_res_t got, want;
    if (rst_n) begin
      if (result_ch.valid && result_ch.ready) begin
        got.alarm   = result_ch.alarm;
        got.prewarn = result_ch.prewarn;
        if (got.alarm === 1'b1) alarms_seen++;
        if (got.prewarn === 1'b1) prewarns_seen++;
        if (alarm_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("[%0t] result with nothing pending: alarm %b prewarn %b",
                     $time, got.alarm, got.prewarn);
          mismatches++;
        end else begin
          want = alarm_q.pop_front();
          if (got.alarm !== want.alarm || got.prewarn !== want.prewarn) begin
            if (mismatches < MAX_REPORTS)
              $display("[%0t] result %0d: alarm exp %b got %b, prewarn exp %b got %b",
                       $time, checked_items, want.alarm, got.alarm,
                       want.prewarn, got.prewarn);
            mismatches++;
          end
          checked_items++;
        end
      end
      if (sample_ch.valid && sample_ch.ready)
        alarm_q.push_back(predict_alarm(sample_ch.probe_present, sample_ch.sample_temp));
      if (sample_ch.valid && !sample_ch.ready) in_stalls++;
      if (cfg_ch.valid && cfg_ch.ready)
        apply_reg_write(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[%0t] timeout, %0d results still pending", $time, alarm_q.size());
      $display("temperature_alarm_hysteresis_tb: done, errors");
      $finish;
    end
  end

  // result receiver: long hold-off on request, otherwise the current mode
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: result_ch.ready <= 1'b1;
        RX_RANDOM: result_ch.ready <= ($urandom_range(0, 9) < 6);
        default: begin
          rx_pat = {rx_pat[6:0], rx_pat[7]};
          result_ch.ready <= rx_pat[0];
        end
      endcase
    end
  end

  // valid stays high on return so the next item can follow back to back
  task automatic send_sample(logic present, logic signed [TEMP_W-1:0] temp);
    @(negedge clk);
    if (gaps_on && burst_left <= 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    sample_ch.valid         <= 1'b1;
    sample_ch.probe_present <= present;
    sample_ch.sample_temp   <= temp;
    do @(posedge clk); while (!sample_ch.ready);
    sent_items++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (alarm_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_limit(int top);
    logic [CFG_DATA_W-1:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) v = '0;
    else if (sel == 2) v = CFG_DATA_W'(2**LIMIT_W - 1);
    else v = CFG_DATA_W'($urandom_range(1, top));
    // bits above the 10-bit field are don't-care
    if ($urandom_range(0, 3) == 0)
      v[CFG_DATA_W-1:LIMIT_W] = (CFG_DATA_W-LIMIT_W)'($urandom);
    return v;
  endfunction

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] vals [2**CFG_IDX_W];
    int sel, tgt, lo, first;
    cfg_idx_t idx;
    sel = $urandom_range(0, 19);
    if (sel == 0) tgt = 0;
    else if (sel == 1) tgt = TEMP_MAX;
    else if (sel == 2) tgt = TEMP_MIN;
    else tgt = int'($urandom_range(0, 11000)) - 1000;
    sel = $urandom_range(0, 9);
    if (sel < 5) lo = 0;
    else if (sel == 5) lo = int'($urandom_range(0, 11000)) - 1000;
    else if (sel == 6) lo = $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
    else lo = tgt - int'($urandom_range(50, 3000));
    vals[REG_TARGET]  = to_temp(tgt);
    vals[REG_MINIMUM] = to_temp(lo);
    vals[REG_MARGIN]  = pick_limit(1000);
    vals[REG_HYST]    = pick_limit(200);
    first = $urandom_range(0, 3);
    for (int k = 0; k < 2**CFG_IDX_W; k++) begin
      idx = cfg_idx_t'(CFG_IDX_W'(first + k));
      if (!((idx == REG_MARGIN || idx == REG_HYST) && $urandom_range(0, 4) == 0))
        write_reg(idx, vals[idx]);
    end
  endtask

  // mostly samples that jitter across a threshold and its re-arm point
  function automatic logic signed [TEMP_W-1:0] next_temp();
    int r, tgt, lo, hyst, anchor, span;
    tgt  = int'($signed(cfg_q.target_temp));
    lo   = int'($signed(cfg_q.minimum_temp));
    hyst = int'(cfg_q.hysteresis);
    span = hyst + 25;
    r    = $urandom_range(0, 99);
    if (r < 70) begin
      if ($urandom_range(0, 1)) anchor = tgt;
      else if (lo == 0) anchor = tgt - int'(cfg_q.prewarn_margin);
      else anchor = lo;
      return to_temp(anchor + int'($urandom_range(0, 2 * span)) - span);
    end
    if (r < 90) return to_temp(int'($urandom_range(0, 11000)) - 1000);
    return TEMP_W'($urandom);
  endfunction

  task automatic test_reset_state();
    // target is 0 out of reset, so nothing fires
    send_sample(1'b1, to_temp(TEMP_MAX));
    send_sample(1'b1, to_temp(TEMP_MIN));
    send_sample(1'b1, to_temp(0));
  endtask

  task automatic test_target_mode();
    wait_drain();
    write_reg(REG_HYST, 20);
    write_reg(REG_MARGIN, 50);
    write_reg(REG_MINIMUM, 0);
    write_reg(REG_TARGET, 500);
    send_sample(1'b0, to_temp(600));  // probe missing
    send_sample(1'b1, to_temp(440));
    send_sample(1'b1, to_temp(450));  // prewarn
    send_sample(1'b1, to_temp(499));
    send_sample(1'b1, to_temp(500));  // alarm
    send_sample(1'b1, to_temp(10000));
    send_sample(1'b1, to_temp(480));  // on the re-arm edge, still latched
    send_sample(1'b1, to_temp(479));
    send_sample(1'b1, to_temp(500));
    send_sample(1'b1, to_temp(429));  // re-arms prewarn
    send_sample(1'b1, to_temp(450));
    send_sample(1'b1, to_temp(TEMP_MAX));
    send_sample(1'b1, to_temp(TEMP_MIN));
  endtask

  task automatic test_range_mode();
    wait_drain();
    write_reg(REG_MINIMUM, 100);
    send_sample(1'b1, to_temp(300));
    send_sample(1'b1, to_temp(99));
    send_sample(1'b1, to_temp(121));
    send_sample(1'b1, to_temp(501));
    send_sample(1'b1, to_temp(480));
    send_sample(1'b1, to_temp(479));
    wait_drain();
    // minimum above target: everything is outside, no re-arm
    write_reg(REG_MINIMUM, 600);
    send_sample(1'b1, to_temp(550));
    send_sample(1'b1, to_temp(300));
  endtask

  task automatic test_output_backpressure();
    wait_drain();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    write_reg(REG_MINIMUM, 0);
    write_reg(REG_TARGET, 700);
    write_reg(REG_MARGIN, 100);
    write_reg(REG_HYST, 30);
    @(posedge clk);
    hold_request = 1'b1;
    repeat (48) send_sample(1'b1, to_temp(int'($urandom_range(560, 760))));
    wait_drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drain();
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_pat  = 8'($urandom_range(1, 255));
      gaps_on = ($urandom_range(0, 3) != 0);
      randomize_config();
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample($urandom_range(0, 9) != 0, next_temp());
    end
  endtask

  initial begin
    sample_ch.valid         = 1'b0;
    sample_ch.probe_present = 1'b0;
    sample_ch.sample_temp   = '0;
    result_ch.ready         = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    rst_n                   = 1'b0;
    cfg_q   = '{target_temp: '0, minimum_temp: '0, prewarn_margin: '0,
                hysteresis: HYST_RESET};
    flags_q = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_target_mode();
    test_range_mode();
    test_output_backpressure();
    test_random_phases();

    wait_drain();
    repeat (LATENCY + 8) @(posedge clk);
    $display("%0d samples, %0d results checked, %0d register writes, %0d alarms, %0d prewarns",
             sent_items, checked_items, cfg_writes, alarms_seen, prewarns_seen);
    $display("target, range and inverted-range settings; input held off %0d cycles",
             in_stalls);
    if (mismatches == 0) begin
      $display("temperature_alarm_hysteresis_tb: done, clean");
    end else begin
      $display("temperature_alarm_hysteresis_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tah_pkg.sv
hdl/tah_if.sv
hdl/tah_eval.sv
hdl/temperature_alarm_hysteresis.sv
hdl/tah_checker.sv
verif/temperature_alarm_hysteresis_tb.sv
